// File: rtl/core/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, off during reset.
`define BCC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every rising edge, including during reset.
`define BCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

  localparam int CNT_W = 10;

  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

  localparam logic [1:0] PH_LOW     = 2'd0;
  localparam logic [1:0] PH_RISING  = 2'd1;
  localparam logic [1:0] PH_HIGH    = 2'd2;
  localparam logic [1:0] PH_FALLING = 2'd3;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  localparam logic [1:0] REG_SHORT = 2'd0;
  localparam logic [1:0] REG_LONG  = 2'd1;
  localparam logic [1:0] REG_STUCK = 2'd2;
  localparam logic [1:0] REG_CLEAR = 2'd3;

  localparam logic [CNT_W-1:0] SHORT_RESET = 10'd1;
  localparam logic [CNT_W-1:0] LONG_RESET  = 10'd20;
  localparam logic [CNT_W-1:0] STUCK_RESET = 10'd200;
  localparam logic [CNT_W-1:0] CLEAR_RESET = 10'd10;

  typedef struct packed {
    logic [CNT_W-1:0] short_press_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] stuck_ticks;
    logic [CNT_W-1:0] clear_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/bcc_cfg_regs.sv
`default_nettype none

module bcc_cfg_regs (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [bcc_pkg::CNT_W-1:0] cfg_data,
  output bcc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_press_ticks <= bcc_pkg::SHORT_RESET;
      cfg.long_press_ticks  <= bcc_pkg::LONG_RESET;
      cfg.stuck_ticks       <= bcc_pkg::STUCK_RESET;
      cfg.clear_ticks       <= bcc_pkg::CLEAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bcc_pkg::REG_SHORT: cfg.short_press_ticks <= cfg_data;
        bcc_pkg::REG_LONG:  cfg.long_press_ticks  <= cfg_data;
        bcc_pkg::REG_STUCK: cfg.stuck_ticks       <= cfg_data;
        bcc_pkg::REG_CLEAR: cfg.clear_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bcc_classify.sv
`default_nettype none
`include "assert_macros.svh"

module bcc_classify (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bcc_pkg::cfg_t cfg,
  input  wire logic          advance,
  input  wire logic          level,
  output logic [1:0]         event_next
);

  logic [1:0]                phase;
  logic [1:0]                phase_next;
  logic [bcc_pkg::CNT_W-1:0] pressed;
  logic [bcc_pkg::CNT_W-1:0] pressed_next;
  logic [bcc_pkg::CNT_W-1:0] released;
  logic [bcc_pkg::CNT_W-1:0] released_next;
  logic [1:0]                remembered;
  logic [1:0]                remembered_next;

  always_comb begin
    if (level) begin
      phase_next = (phase == bcc_pkg::PH_LOW) ? bcc_pkg::PH_RISING : bcc_pkg::PH_HIGH;
    end else begin
      phase_next = (phase == bcc_pkg::PH_HIGH) ? bcc_pkg::PH_FALLING : bcc_pkg::PH_LOW;
    end

    pressed_next  = pressed;
    released_next = released;
    case (phase_next)
      bcc_pkg::PH_HIGH: begin
        pressed_next  = (pressed == bcc_pkg::COUNT_MAX) ? pressed : pressed + 1'b1;
        released_next = '0;
      end
      bcc_pkg::PH_LOW: begin
        pressed_next  = '0;
        released_next = (released == bcc_pkg::COUNT_MAX) ? released : released + 1'b1;
      end
      default: ;
    endcase

    event_next = bcc_pkg::EV_NONE;
    if (phase_next == bcc_pkg::PH_FALLING) begin
      if (pressed_next >= cfg.stuck_ticks) begin
        event_next = bcc_pkg::EV_NONE;
      end else if (pressed_next >= cfg.long_press_ticks) begin
        event_next = bcc_pkg::EV_LONG;
      end else if (pressed_next >= cfg.short_press_ticks) begin
        if (remembered == bcc_pkg::EV_SINGLE && released_next <= cfg.clear_ticks) begin
          event_next = bcc_pkg::EV_DOUBLE;
        end else begin
          event_next = bcc_pkg::EV_SINGLE;
        end
      end
    end

    if (released_next >= cfg.clear_ticks) begin
      remembered_next = bcc_pkg::EV_NONE;
    end else if (event_next != bcc_pkg::EV_NONE) begin
      remembered_next = event_next;
    end else begin
      remembered_next = remembered;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= bcc_pkg::PH_LOW;
      pressed    <= '0;
      released   <= '0;
      remembered <= bcc_pkg::EV_NONE;
    end else if (advance) begin
      phase      <= phase_next;
      pressed    <= pressed_next;
      released   <= released_next;
      remembered <= remembered_next;
    end
  end

  `BCC_ASSERT(a_event_on_falling, clk, rst,
    (event_next != bcc_pkg::EV_NONE) |-> (phase_next == bcc_pkg::PH_FALLING),
    "click event outside a falling phase")
  `BCC_ASSERT(a_double_needs_single, clk, rst,
    (event_next == bcc_pkg::EV_DOUBLE) |-> (remembered == bcc_pkg::EV_SINGLE),
    "double click without a remembered single click")
  `BCC_ASSERT(a_counts_exclusive, clk, rst,
    (pressed != '0) |-> (released == '0),
    "pressed and released counts both running")

endmodule

`default_nettype wire

// File: rtl/core/button_click_classifier.sv
// Button click classifier.
// Input stream (s_tvalid/s_tready/s_tdata) carries one sampled button level per
// transaction in s_tdata[0]. Output stream (m_tvalid/m_tready/m_tdata) returns
// exactly one click code per input transaction in m_tdata[1:0]:
// 0 none, 1 single, 2 double, 3 long.
// Throughput: one transaction per cycle while m_tready is high; the input
// register and the result register form a two-stage pipe, so a new sample is
// taken while a result waits. When m_tready is low the result holds, the input
// register fills, and then s_tready drops until the result is taken; nothing
// is lost or repeated.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 short press,
// 1 long press, 2 stuck, 3 clear limits); write only while idle.
// Reset (rst, synchronous) empties both stages, returns the level state to low,
// clears the counts and the remembered click, and loads the default limits.
`default_nettype none
`include "assert_macros.svh"

module button_click_classifier (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,   // [0] pin_level, [7:1] zero
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [7:0]                     m_tdata,   // [1:0] click_event, [7:2] zero
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [bcc_pkg::CNT_W-1:0] cfg_data
);

  bcc_pkg::cfg_t cfg;
  logic          in_valid;
  logic          in_level;
  logic          advance;
  logic [1:0]    event_next;
  logic [1:0]    click_event;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = {6'b0, click_event};

  bcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .advance    (advance),
    .level      (in_level),
    .event_next (event_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_level <= s_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      click_event <= event_next;
    end
  end

  `BCC_ASSERT(a_stall_means_full, clk, rst,
    !s_tready |-> (in_valid && m_tvalid && !m_tready),
    "input stalled while the pipe has room")
  `BCC_ASSERT(a_advance_fills_output, clk, rst,
    advance |=> m_tvalid,
    "advanced sample produced no result")

endmodule

`default_nettype wire
